@@ sv/vfn_pkg.sv @@
`default_nettype none
package vfn_pkg;

  localparam int CompW  = 16;
  localparam int SumW   = 32;
  localparam int RemW   = 18;
  localparam int QHalf  = 32768;

  // Control beat from the sequencer to the shared compare-subtract unit
  typedef struct packed {
    logic load;       // start a new root or quotient
    logic step;       // one result bit
    logic sqrt_mode;  // 1: square root, 0: division
  } vfn_ctl_t;

endpackage
`default_nettype wire

@@ sv/vfn_cs_unit.sv @@
`default_nettype none
// Shared compare-subtract unit: one root bit or one quotient bit per step.
module vfn_cs_unit (
  input  wire logic                    clk,
  input  wire vfn_pkg::vfn_ctl_t       ctl,
  input  wire logic [vfn_pkg::SumW-1:0]  sum,
  input  wire logic [vfn_pkg::CompW-1:0] div_hi,
  input  wire logic [vfn_pkg::CompW-1:0] divisor,
  output logic      [vfn_pkg::CompW-1:0] q,
  output logic                         rem_nz
);
  import vfn_pkg::*;

  logic [RemW-1:0] rem;
  logic [SumW-1:0] src;
  logic [RemW:0]   shifted;
  logic [RemW:0]   trial;
  logic [RemW+1:0] diff;
  logic            ge;

  always_comb begin
    if (ctl.sqrt_mode) begin
      shifted = {rem[RemW-2:0], src[SumW-1:SumW-2]};
      trial   = {1'b0, q, 2'b01};
    end else begin
      shifted = {rem, 1'b0};
      trial   = {{(RemW+1-CompW){1'b0}}, divisor};
    end
    diff = {1'b0, shifted} - {1'b0, trial};
    ge   = !diff[RemW+1];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q   <= '0;
      src <= sum;
      rem <= ctl.sqrt_mode ? '0 : {{(RemW-CompW){1'b0}}, div_hi};
    end else if (ctl.step) begin
      q   <= {q[CompW-2:0], ge};
      src <= {src[SumW-3:0], 2'b00};
      rem <= ge ? diff[RemW-1:0] : shifted[RemW-1:0];
    end
  end

  assign rem_nz = (rem != '0);

endmodule
`default_nettype wire

@@ sv/vector_field_normalizer.sv @@
`default_nettype none
// Vector magnitude measure and normalize block. Each input beat carries one
// vector (signed 16-bit x, y, z) and a command, and yields exactly one output
// beat. A measure beat (cmd 0) computes the floor magnitude and folds it into
// the stored maximum and minimum (first_vector restarts both). A normalize
// beat (cmd 1) returns magnitude/peak and c/(2*peak)+0.5 per component as
// unsigned Q0.16, clamped; with a zero peak it flags zero_peak and returns
// 0 and 32768. The root and the quotients run through one compare-subtract
// unit, one result bit per cycle, under a small sequencer, so the block takes
// one beat at a time: in_stall is high from acceptance until the result is
// handed to the output register. A measure beat squares and accumulates x, y
// and z, loads the sum into the unit, takes 16 root steps, takes the magnitude
// and extremes, and hands off; the idle state then takes the next beat. A
// normalize beat with a nonzero peak runs, before the handoff, the magnitude
// quotient (16 steps) and one quotient per component (15 steps each); a
// quotient that saturates skips its steps. A stalled output holds the handoff
// while the output register is full. The output register lets the next beat
// start while a result still waits.
module vector_field_normalizer (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           cmd,
  input  wire logic                           first_vector,
  input  wire logic signed [vfn_pkg::CompW-1:0] comp_x,
  input  wire logic signed [vfn_pkg::CompW-1:0] comp_y,
  input  wire logic signed [vfn_pkg::CompW-1:0] comp_z,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [vfn_pkg::CompW-1:0]           magnitude,
  output logic [vfn_pkg::CompW-1:0]           norm_magnitude,
  output logic [vfn_pkg::CompW-1:0]           norm_x,
  output logic [vfn_pkg::CompW-1:0]           norm_y,
  output logic [vfn_pkg::CompW-1:0]           norm_z,
  output logic [vfn_pkg::CompW-1:0]           peak_magnitude,
  output logic [vfn_pkg::CompW-1:0]           least_magnitude,
  output logic                                zero_peak
);
  import vfn_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SQ    = 3'd1;  // square and accumulate x, y, z
  localparam logic [2:0] S_ROOT  = 3'd2;  // 16 root steps
  localparam logic [2:0] S_MAG   = 3'd3;  // take magnitude, update extremes
  localparam logic [2:0] S_DLOAD = 3'd4;  // set up one quotient or saturate
  localparam logic [2:0] S_DIV   = 3'd5;  // quotient steps
  localparam logic [2:0] S_DRES  = 3'd6;  // fold quotient into result
  localparam logic [2:0] S_FIN   = 3'd7;  // hand result to output register

  localparam logic [3:0] MagSteps  = 4'd15;  // last step index, 16 bits
  localparam logic [3:0] CompSteps = 4'd14;  // last step index, 15 bits
  localparam logic [CompW-1:0] HalfQ = CompW'(QHalf);
  localparam logic [CompW-1:0] AllOnes = '1;

  logic [2:0] state;
  logic [3:0] cnt;
  logic [1:0] job;     // 0: magnitude, 1..3: x, y, z
  logic [1:0] sq_idx;

  // captured beat
  logic                    cmd_r;
  logic                    first_r;
  logic signed [CompW-1:0] comp [3];

  logic [SumW-1:0]  sum;
  logic [CompW-1:0] mag;
  logic [CompW-1:0] res [4];
  logic             zp;

  logic [CompW-1:0] peak_store;
  logic [CompW-1:0] least_store;

  // square of the selected component
  logic signed [CompW-1:0] sq_sel;
  logic signed [SumW-1:0]  prod;

  // current quotient job
  logic signed [CompW-1:0] job_comp;
  logic                    job_neg;
  logic [CompW-1:0]        hi;
  logic                    hi_sat;
  logic [CompW:0]          neg_res;

  vfn_ctl_t         ctl;
  logic [CompW-1:0] uq;
  logic             urem_nz;

  vfn_cs_unit u_cs (
    .clk     (clk),
    .ctl     (ctl),
    .sum     (sum),
    .div_hi  (hi),
    .divisor (peak_store),
    .q       (uq),
    .rem_nz  (urem_nz)
  );

  assign in_stall = (state != S_IDLE);

  always_comb begin
    sq_sel   = comp[sq_idx];
    prod     = sq_sel * sq_sel;
    job_comp = comp[2'(job - 2'd1)];
    job_neg  = (job != 2'd0) && job_comp[CompW-1];
    if (job == 2'd0) begin
      hi = mag;
    end else if (job_neg) begin
      hi = CompW'(-job_comp);  // -(-32768) wraps to 32768, right as unsigned
    end else begin
      hi = job_comp;
    end
    hi_sat  = (hi >= peak_store);
    // 32768 - ceil(|c| * 32768 / peak), never negative when not saturated
    neg_res = {1'b0, HalfQ} - {2'b00, uq[CompW-2:0]} - {{CompW{1'b0}}, urem_nz};

    ctl.load      = 1'b0;
    ctl.step      = 1'b0;
    ctl.sqrt_mode = (state == S_SQ) || (state == S_ROOT);
    case (state)
      S_SQ: begin
        ctl.load = (sq_idx == 2'd3);
      end
      S_ROOT: begin
        ctl.step = 1'b1;
      end
      S_DLOAD: begin
        ctl.load = !hi_sat;
      end
      S_DIV: begin
        ctl.step = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      job         <= '0;
      sq_idx      <= '0;
      peak_store  <= '0;
      least_store <= '1;
      out_valid   <= 1'b0;
    end else begin
      // a handoff in S_FIN refills the output register in the same cycle
      if (out_valid && !out_stall && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= cmd;
            first_r <= first_vector;
            comp[0] <= comp_x;
            comp[1] <= comp_y;
            comp[2] <= comp_z;
            sum     <= '0;
            sq_idx  <= '0;
            state   <= S_SQ;
          end
        end
        S_SQ: begin
          // the unit loads the finished sum once all three squares are accumulated
          if (sq_idx == 2'd3) begin
            cnt   <= '0;
            state <= S_ROOT;
          end else begin
            sum    <= sum + SumW'($unsigned(prod));
            sq_idx <= sq_idx + 2'd1;
          end
        end
        S_ROOT: begin
          cnt <= cnt + 4'd1;
          if (cnt == MagSteps) begin
            state <= S_MAG;
          end
        end
        S_MAG: begin
          mag    <= uq;
          res[0] <= '0;
          res[1] <= '0;
          res[2] <= '0;
          res[3] <= '0;
          zp     <= 1'b0;
          job    <= '0;
          if (!cmd_r) begin
            if (first_r) begin
              peak_store  <= uq;
              least_store <= uq;
            end else begin
              if (uq > peak_store) peak_store <= uq;
              if (uq < least_store) least_store <= uq;
            end
            state <= S_FIN;
          end else if (peak_store == '0) begin
            zp     <= 1'b1;
            res[1] <= HalfQ;
            res[2] <= HalfQ;
            res[3] <= HalfQ;
            state  <= S_FIN;
          end else begin
            state <= S_DLOAD;
          end
        end
        S_DLOAD: begin
          cnt <= '0;
          if (hi_sat) begin
            res[job] <= job_neg ? '0 : AllOnes;
            job      <= job + 2'd1;
            state    <= (job == 2'd3) ? S_FIN : S_DLOAD;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          cnt <= cnt + 4'd1;
          if (cnt == ((job == 2'd0) ? MagSteps : CompSteps)) begin
            state <= S_DRES;
          end
        end
        S_DRES: begin
          if (job == 2'd0) begin
            res[0] <= uq;
          end else if (job_neg) begin
            res[job] <= neg_res[CompW-1:0];
          end else begin
            res[job] <= {1'b1, uq[CompW-2:0]};
          end
          job   <= job + 2'd1;
          state <= (job == 2'd3) ? S_FIN : S_DLOAD;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register, loaded as the result leaves the sequencer
  always_ff @(posedge clk) begin
    if ((state == S_FIN) && (!out_valid || !out_stall)) begin
      magnitude       <= mag;
      norm_magnitude  <= res[0];
      norm_x          <= res[1];
      norm_y          <= res[2];
      norm_z          <= res[3];
      peak_magnitude  <= peak_store;
      least_magnitude <= least_store;
      zero_peak       <= zp;
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/tb_vector_field_normalizer.sv @@
`default_nettype none
module tb_vector_field_normalizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = vfn_pkg::CompW;

  // Command encoding on the cmd input
  localparam logic CMD_MEASURE   = 1'b0;
  localparam logic CMD_NORMALIZE = 1'b1;

  // Q0.16 constants used by the scaling math
  localparam longint Q16_ONE  = 65536;
  localparam longint Q16_HALF = vfn_pkg::QHalf;
  localparam longint Q16_MAX  = 65535;

  localparam int RANDOM_ITEMS = 800;
  // Cycles without any beat on either side before the run is declared hung.
  // Worst legit gap: a full normalize beat plus the receiver hold-off
  // plus random stall runs; this leaves a wide margin.
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 120;

  // One expected output beat, field for field
  typedef struct packed {
    logic [W-1:0] magnitude;
    logic [W-1:0] norm_magnitude;
    logic [W-1:0] norm_x;
    logic [W-1:0] norm_y;
    logic [W-1:0] norm_z;
    logic [W-1:0] peak_magnitude;
    logic [W-1:0] least_magnitude;
    logic         zero_peak;
  } norm_beat_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                cmd = CMD_MEASURE;
  logic                first_vector = 1'b0;
  logic signed [W-1:0] comp_x = '0;
  logic signed [W-1:0] comp_y = '0;
  logic signed [W-1:0] comp_z = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [W-1:0]        magnitude;
  logic [W-1:0]        norm_magnitude;
  logic [W-1:0]        norm_x;
  logic [W-1:0]        norm_y;
  logic [W-1:0]        norm_z;
  logic [W-1:0]        peak_magnitude;
  logic [W-1:0]        least_magnitude;
  logic                zero_peak;

  // Predictor copy of the extreme-value registers
  logic [W-1:0] peak_track  = '0;
  logic [W-1:0] least_track = '1;

  norm_beat_t   pending_beats[$];
  int           mismatches = 0;
  int           items_sent = 0;
  int           idle_cycles = 0;
  // steady: no random idling on either side; hold_len: receiver hold-off
  bit           steady = 1'b0;
  int           hold_len = 0;

  vector_field_normalizer uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .first_vector   (first_vector),
    .comp_x         (comp_x),
    .comp_y         (comp_y),
    .comp_z         (comp_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .magnitude      (magnitude),
    .norm_magnitude (norm_magnitude),
    .norm_x         (norm_x),
    .norm_y         (norm_y),
    .norm_z         (norm_z),
    .peak_magnitude (peak_magnitude),
    .least_magnitude(least_magnitude),
    .zero_peak      (zero_peak)
  );

  always #5 clk = ~clk;

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------

  // Bitwise floor square root; sum of three squares fits in 32 bits
  function automatic logic [W-1:0] floor_sqrt(input logic [31:0] n);
    logic [31:0] rem;
    logic [31:0] root;
    logic [31:0] probe;
    rem   = n;
    root  = '0;
    probe = 32'h4000_0000;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root[W-1:0];
  endfunction

  // floor(c * 32768 / peak) + 32768, division toward minus infinity, clamped
  function automatic logic [W-1:0] scale_component(input logic signed [W-1:0] c,
                                                   input logic [W-1:0] peak);
    longint num;
    longint den;
    longint q;
    num = longint'(c) * Q16_HALF;
    den = longint'(peak);
    q   = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    q = q + Q16_HALF;
    if (q < 0) q = 0;
    if (q > Q16_MAX) q = Q16_MAX;
    return q[W-1:0];
  endfunction

  // Works out the beat for one accepted vector and updates the extremes
  function automatic norm_beat_t predict_beat(input logic op, input logic restart,
                                              input logic signed [W-1:0] x,
                                              input logic signed [W-1:0] y,
                                              input logic signed [W-1:0] z);
    norm_beat_t beat;
    longint     sum;
    longint     q;
    logic [W-1:0] mag;
    sum = longint'(x) * longint'(x) + longint'(y) * longint'(y)
        + longint'(z) * longint'(z);
    mag  = floor_sqrt(sum[31:0]);
    beat = '0;
    beat.magnitude = mag;
    if (op == CMD_MEASURE) begin
      if (restart) begin
        peak_track  = mag;
        least_track = mag;
      end else begin
        if (mag > peak_track)  peak_track  = mag;
        if (mag < least_track) least_track = mag;
      end
    end else if (peak_track == 0) begin
      // nothing to scale against: flag it, return the midpoint
      beat.zero_peak = 1'b1;
      beat.norm_x    = Q16_HALF[W-1:0];
      beat.norm_y    = Q16_HALF[W-1:0];
      beat.norm_z    = Q16_HALF[W-1:0];
    end else begin
      q = longint'(mag) * Q16_ONE / longint'(peak_track);
      beat.norm_magnitude = (q > Q16_MAX) ? Q16_MAX[W-1:0] : q[W-1:0];
      beat.norm_x = scale_component(x, peak_track);
      beat.norm_y = scale_component(y, peak_track);
      beat.norm_z = scale_component(z, peak_track);
    end
    beat.peak_magnitude  = peak_track;
    beat.least_magnitude = least_track;
    return beat;
  endfunction

  // ------------------------------------------------------------------
  // Input side: one beat per call, gaps decided at the falling edge.
  // in_valid is only written once per falling edge, so back-to-back
  // beats keep it high without a glitch.
  // ------------------------------------------------------------------
  task automatic send_vector(input logic op, input logic restart,
                             input logic signed [W-1:0] x,
                             input logic signed [W-1:0] y,
                             input logic signed [W-1:0] z);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= op;
    first_vector <= restart;
    comp_x       <= x;
    comp_y       <= y;
    comp_z       <= z;
    // beat is taken at the first rising edge with in_stall low
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_beats.push_back(predict_beat(op, restart, x, y, z));
    items_sent++;
  endtask

  // Signed component of roughly 'bits' bits of magnitude, both signs
  function automatic logic signed [W-1:0] rand_component(input int bits);
    logic signed [W-1:0] raw;
    raw = W'($urandom);
    return raw >>> (W - bits);
  endfunction

  // ------------------------------------------------------------------
  // Output side: random stalls, plus a counted hold-off when requested
  // ------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len = hold_len - 1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 20);
    end
  end

  task automatic compare_field(input string name, input logic [W-1:0] want,
                               input logic [W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // Every output beat is held against the oldest prediction
  always @(posedge clk) begin : result_check
    norm_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat, expected none actual magnitude %0d",
                 $time, magnitude);
      end else begin
        want = pending_beats.pop_front();
        compare_field("magnitude", want.magnitude, magnitude);
        compare_field("norm_magnitude", want.norm_magnitude, norm_magnitude);
        compare_field("norm_x", want.norm_x, norm_x);
        compare_field("norm_y", want.norm_y, norm_y);
        compare_field("norm_z", want.norm_z, norm_z);
        compare_field("peak_magnitude", want.peak_magnitude, peak_magnitude);
        compare_field("least_magnitude", want.least_magnitude, least_magnitude);
        compare_field("zero_peak", W'(want.zero_peak), W'(zero_peak));
      end
    end
  end

  // Hang detector: counts cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Normalize straight after reset: peak is zero, first_vector ignored
  task automatic test_zero_peak_after_reset();
    send_vector(CMD_NORMALIZE, 1'b1, 16'sd100, -16'sd200, 16'sd300);
    send_vector(CMD_NORMALIZE, 1'b0, -16'sd32768, 16'sd32767, 16'sd0);
  endtask

  // Measure with no restart: reset values act as empty extremes.
  // Then saturation: magnitude above peak and components beyond +-peak.
  task automatic test_unrestarted_measure();
    send_vector(CMD_MEASURE, 1'b0, 16'sd3, 16'sd4, 16'sd0);
    send_vector(CMD_MEASURE, 1'b0, 16'sd0, 16'sd0, 16'sd0);
    send_vector(CMD_NORMALIZE, 1'b0, 16'sd3, 16'sd4, 16'sd0);
    send_vector(CMD_NORMALIZE, 1'b0, -16'sd5, 16'sd0, 16'sd0);
    send_vector(CMD_NORMALIZE, 1'b0, 16'sd32767, -16'sd32768, 16'sd0);
  endtask

  // Largest possible magnitude and field extremes
  task automatic test_extreme_vectors();
    send_vector(CMD_MEASURE, 1'b1, -16'sd32768, -16'sd32768, -16'sd32768);
    send_vector(CMD_MEASURE, 1'b0, 16'sd32767, 16'sd32767, 16'sd32767);
    send_vector(CMD_MEASURE, 1'b0, 16'sd0, 16'sd0, 16'sd1);
    send_vector(CMD_NORMALIZE, 1'b0, -16'sd32768, -16'sd32768, -16'sd32768);
    send_vector(CMD_NORMALIZE, 1'b0, 16'sd32767, 16'sd0, -16'sd1);
    send_vector(CMD_NORMALIZE, 1'b0, 16'sd0, 16'sd0, 16'sd0);
  endtask

  // Restart to a zero peak, then the smallest nonzero peak
  task automatic test_zero_peak_restart();
    send_vector(CMD_MEASURE, 1'b1, 16'sd0, 16'sd0, 16'sd0);
    send_vector(CMD_NORMALIZE, 1'b0, 16'sd1, 16'sd1, 16'sd1);
    send_vector(CMD_MEASURE, 1'b0, 16'sd0, -16'sd1, 16'sd0);
    send_vector(CMD_NORMALIZE, 1'b0, 16'sd1, -16'sd1, 16'sd0);
    send_vector(CMD_NORMALIZE, 1'b1, 16'sd2, 16'sd0, 16'sd0);
  endtask

  // Restart mid-run drops the old extremes
  task automatic test_restart();
    send_vector(CMD_MEASURE, 1'b1, 16'sd1000, 16'sd0, 16'sd0);
    send_vector(CMD_MEASURE, 1'b0, 16'sd0, 16'sd2000, 16'sd0);
    send_vector(CMD_NORMALIZE, 1'b0, 16'sd500, -16'sd1000, 16'sd1500);
  endtask

  // Receiver holds off while the sender keeps pushing: the block and its
  // output register fill and in_stall must hold the input side
  task automatic test_backpressure();
    steady   = 1'b1;
    hold_len = HOLD_CYCLES;
    for (int i = 0; i < 8; i++)
      send_vector(i[0], i == 0, rand_component(16), rand_component(12),
                  rand_component(16));
    steady = 1'b0;
  endtask

  // Mostly well-formed measure/normalize passes with random content,
  // some zero-peak passes and some arbitrary beats. The first stretch
  // runs with no idling at all.
  task automatic test_random_passes();
    int base;
    int kind;
    int scale;
    int n;
    base   = items_sent;
    steady = 1'b1;
    while (items_sent - base < RANDOM_ITEMS) begin
      if (items_sent - base > 150) steady = 1'b0;
      kind  = $urandom_range(99);
      scale = ($urandom_range(3) == 0) ? W : $urandom_range(1, W);
      if (kind < 75) begin
        // measure pass, usually restarted, then normalize against it
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++)
          send_vector(CMD_MEASURE, (i == 0) && ($urandom_range(4) != 0),
                      rand_component(scale), rand_component(scale),
                      rand_component(scale));
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(4) == 0) scale = $urandom_range(1, W);
          send_vector(CMD_NORMALIZE, 1'($urandom_range(1)),
                      rand_component(scale), rand_component(scale),
                      rand_component(scale));
        end
      end else if (kind < 85) begin
        // zero-magnitude restart leaves a zero peak
        send_vector(CMD_MEASURE, 1'b1, 16'sd0, 16'sd0, 16'sd0);
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          send_vector(CMD_NORMALIZE, 1'($urandom_range(1)), rand_component(W),
                      rand_component(W), rand_component(W));
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          send_vector(1'($urandom_range(1)), 1'($urandom_range(1)),
                      rand_component($urandom_range(1, W)),
                      rand_component($urandom_range(1, W)),
                      rand_component($urandom_range(1, W)));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_zero_peak_after_reset();
    test_unrestarted_measure();
    test_extreme_vectors();
    test_zero_peak_restart();
    test_restart();
    test_backpressure();
    test_random_passes();

    @(negedge clk);
    in_valid <= 1'b0;
    // hang detector bounds this wait
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire
